// ----- hdl/ppa_pkg.sv -----
// Shared codes for the per-CPU page allocator: operation codes, status codes,
// configuration register indexes and reset values of the region registers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppa_pkg;

    localparam int DATA_W = 32;

    // Operation codes on func
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_REGION_START = 1'b0;
    localparam logic CFG_REGION_END   = 1'b1;

    localparam logic [DATA_W-1:0] REGION_START_RST = 32'h8000_0000;
    localparam logic [DATA_W-1:0] REGION_END_RST   = 32'h8800_0000;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADADDR = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ----- hdl/ppa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ppa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ppa_free_check.sv -----
// Address check for a page free: alignment, region bounds and page index.
// Depends on ppa_pkg. PAGE_BYTES must be a power of two.
`timescale 1ns / 1ps
`default_nettype none

module ppa_free_check
    import ppa_pkg::*;
#(
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic [DATA_W-1:0]          addr,
    input  wire logic [DATA_W-1:0]          region_start,
    input  wire logic [DATA_W-1:0]          region_end,
    input  wire logic [DATA_W:0]            base,
    output logic                            bad,
    output logic [$clog2(NUM_PAGES)-1:0]    idx
);

    localparam int OB = $clog2(PAGE_BYTES);
    localparam int PW = $clog2(NUM_PAGES);

    logic [DATA_W-1:0] diff;
    logic [DATA_W:0]   offs;
    logic              misaligned;

    // Page offset from the base, then range checks
    assign diff       = addr - base[DATA_W-1:0];
    assign offs       = {1'b0, diff} >> OB;
    assign misaligned = (addr[OB-1:0] != '0);
    assign idx        = offs[PW-1:0];

    assign bad = misaligned
              || (addr < region_start)
              || (addr >= region_end)
              || ({1'b0, addr} < base)
              || (offs >= (DATA_W+1)'(NUM_PAGES));

endmodule

`default_nettype wire

// ----- hdl/percpu_page_allocator_core.sv -----
// Top level of the per-CPU page allocator: list heads, control sequence and
// result register. Depends on ppa_pkg, ppa_ram and ppa_free_check.
`timescale 1ns / 1ps
`default_nettype none

// Each operation has a start cycle, in which the list is chosen and the
// link table read is issued, and an execute cycle, in which the link table
// and the list head are written back. busy is high during the execute cycle,
// so no new start is taken during the execute cycle. The result
// appears on page_addr/status with done high for one cycle right after the
// execute cycle and must be captured then; there is no way to stall it.
// An allocate whose own list is empty takes the head of the lowest-numbered
// other non-empty list. The link table is a single NUM_PAGES-entry RAM with
// no clearing pass; lists are empty after reset. PAGE_BYTES must be a power
// of two. Double frees are not detected.
module percpu_page_allocator_core
    import ppa_pkg::*;
#(
    parameter int NUM_CPUS   = 8,
    parameter int NUM_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [2:0]        cpu,
    input  wire logic [DATA_W-1:0] addr,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    output logic                   done,
    output logic [DATA_W-1:0]      page_addr,
    output logic [1:0]             status
);

    localparam int OB = $clog2(PAGE_BYTES);
    localparam int PW = $clog2(NUM_PAGES);
    localparam int LW = PW + 1;
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    function automatic logic [DATA_W:0] round_base(input logic [DATA_W-1:0] s);
        logic [DATA_W:0] t;
        t = {1'b0, s} + (DATA_W+1)'(PAGE_BYTES - 1);
        t[OB-1:0] = '0;
        return t;
    endfunction

    function automatic logic [CW-1:0] cpu_wrap(input logic [2:0] c);
        logic [4:0] v;
        v = {2'b00, c};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= 5'(NUM_CPUS))
            begin
                v = v - 5'(NUM_CPUS);
            end
        end
        return v[CW-1:0];
    endfunction

    // Registers
    state_t              state_reg, state_next;
    logic [DATA_W-1:0]   region_start_reg, region_end_reg;
    logic [DATA_W:0]     base_reg;
    logic                head_valid_reg [NUM_CPUS];
    logic                head_valid_next [NUM_CPUS];
    logic [PW-1:0]       head_page_reg [NUM_CPUS];
    logic [PW-1:0]       head_page_next [NUM_CPUS];
    logic                op_func_reg;
    logic [CW-1:0]       op_cpu_reg;
    logic [CW-1:0]       sel_reg;
    logic                found_reg;
    logic [DATA_W-1:0]   addr_reg;
    logic                done_reg, done_next;
    logic [DATA_W-1:0]   page_addr_reg, page_addr_next;
    status_t             status_reg, status_next;

    // Combinational
    logic                accept;
    logic [CW-1:0]       own_cpu;
    logic [CW-1:0]       sel_cpu;
    logic                sel_found;
    logic                chk_bad;
    logic [PW-1:0]       chk_idx;
    logic                mem_we;
    logic [PW-1:0]       mem_waddr;
    logic [LW-1:0]       mem_wdata;
    logic [LW-1:0]       mem_rdata;
    logic [DATA_W-1:0]   page_off;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    // Choose the list: own list first, then the lowest other non-empty one
    always_comb
    begin
        own_cpu   = cpu_wrap(cpu);
        sel_cpu   = own_cpu;
        sel_found = head_valid_reg[own_cpu];
        for (int c = 0; c < NUM_CPUS; c++)
        begin
            if (!sel_found && head_valid_reg[c])
            begin
                sel_cpu   = CW'(c);
                sel_found = 1'b1;
            end
        end
    end

    ppa_free_check #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_check (
        .addr         (addr_reg),
        .region_start (region_start_reg),
        .region_end   (region_end_reg),
        .base         (base_reg),
        .bad          (chk_bad),
        .idx          (chk_idx)
    );

    ppa_ram #(
        .WIDTH (LW),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (accept),
        .raddr (head_page_reg[sel_cpu]),
        .rdata (mem_rdata)
    );

    // Push on a good free: link the page in front of the current head
    assign mem_we    = (state_reg == S_EXEC) && (op_func_reg == FUNC_FREE) && !chk_bad;
    assign mem_waddr = chk_idx;
    assign mem_wdata = head_valid_reg[op_cpu_reg] ? {1'b0, head_page_reg[op_cpu_reg]}
                                                  : {1'b1, PW'(0)};

    assign page_off = DATA_W'(head_page_reg[sel_reg]) << OB;

    // Next-state logic for the idle and execute cycles
    always_comb
    begin
        state_next      = state_reg;
        head_valid_next = head_valid_reg;
        head_page_next  = head_page_reg;
        done_next       = 1'b0;
        page_addr_next  = page_addr_reg;
        status_next     = status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (op_func_reg == FUNC_FREE)
                begin
                    page_addr_next = '0;
                    if (chk_bad)
                    begin
                        status_next = ST_BADADDR;
                    end
                    else
                    begin
                        status_next                 = ST_OK;
                        head_valid_next[op_cpu_reg] = 1'b1;
                        head_page_next[op_cpu_reg]  = chk_idx;
                    end
                end
                else if (!found_reg)
                begin
                    page_addr_next = '0;
                    status_next    = ST_NOMEM;
                end
                else
                begin
                    status_next    = ST_OK;
                    page_addr_next = base_reg[DATA_W-1:0] + page_off;
                    // Advance the head, drop the list when the end mark is read
                    if (mem_rdata[LW-1])
                    begin
                        head_valid_next[sel_reg] = 1'b0;
                    end
                    else
                    begin
                        head_page_next[sel_reg] = mem_rdata[PW-1:0];
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, list heads, config and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            region_start_reg <= REGION_START_RST;
            region_end_reg   <= REGION_END_RST;
            base_reg         <= round_base(REGION_START_RST);
            done_reg         <= 1'b0;
            for (int c = 0; c < NUM_CPUS; c++)
            begin
                head_valid_reg[c] <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            done_reg       <= done_next;
            head_valid_reg <= head_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_REGION_START:
                    begin
                        region_start_reg <= cfg_data;
                        base_reg         <= round_base(cfg_data);
                    end
                    CFG_REGION_END:
                    begin
                        region_end_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers: capture the transfer and the result
    always_ff @(posedge clk)
    begin
        head_page_reg <= head_page_next;
        page_addr_reg <= page_addr_next;
        status_reg    <= status_next;
        if (accept)
        begin
            op_func_reg <= func;
            op_cpu_reg  <= own_cpu;
            sel_reg     <= sel_cpu;
            found_reg   <= sel_found;
            addr_reg    <= addr;
        end
    end

    assign done      = done_reg;
    assign page_addr = page_addr_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire
